@@ design/mvm_pkg.sv @@
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types, command codes and constants for the mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package mvm_pkg;

	typedef enum logic [2:0] {
		CMD_PLAY    = 3'd0,
		CMD_WRITE   = 3'd1,
		CMD_SPATIAL = 3'd2,
		CMD_STOP    = 3'd3,
		CMD_STOPALL = 3'd4,
		CMD_MIX     = 3'd5,
		CMD_QUERY   = 3'd6
	} cmd_t;

	typedef struct packed {
		cmd_t               op;
		logic [3:0]         voice;
		logic [12:0]        sample_index;
		logic signed [15:0] sample_value;
		logic [12:0]        frame_count;
		logic               stereo;
		logic [15:0]        volume;
		logic signed [15:0] pan;
		logic [15:0]        lowpass;
		logic               loop_enable;
		logic               voice_ok;
		logic               index_ok;
		logic               frames_ok;
	} cmd_item_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	localparam longint HALF_PI_Q30  = 64'sd1686629713;
	localparam int     LP_THRESHOLD = 65;
	localparam int     LP_SCALE     = 62259;

endpackage

`default_nettype wire

@@ design/multi_voice_audio_mixer_top.sv @@
// A non-mix command passes through the queue; the engine then registers its result.
// A mix frame checks each voice in turn, reads and scales each active one into both
// sums, low-pass filtering it first when that is on, and then registers the result.
// One command runs at a time in the voice engine; a 4-deep queue takes input meanwhile.
// Reset clears all voices to idle; the sample store is not cleared.
// ----------------------------------------------------------------------------
// multi_voice_audio_mixer_top
// Sample-playback mixer: command front end, queue and voice engine.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_voice_audio_mixer_top #(
	parameter int VOICES       = 16,
	parameter int VOICE_FRAMES = 4096,
	parameter int PAN_STEPS    = 256
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// cmd, voice, sample_index, sample_value, frame_count, stereo, volume, pan,
	// lowpass, loop_enable
	input  wire logic [103:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// left_out, right_out, voice_id, status, active_count, finished
	output logic [47:0]       m_axis_tdata
);

	logic               q_full;
	logic               q_push;
	logic               q_pop;
	logic               q_valid;
	mvm_pkg::cmd_item_t q_in;
	mvm_pkg::cmd_item_t q_out;

	mvm_front #(
		.VOICES      (VOICES),
		.VOICE_FRAMES(VOICE_FRAMES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_item       (q_in)
	);

	mvm_cmd_q u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.item_valid(q_valid),
		.item      (q_out)
	);

	mvm_engine #(
		.VOICES      (VOICES),
		.VOICE_FRAMES(VOICE_FRAMES),
		.PAN_STEPS   (PAN_STEPS)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (q_valid),
		.item         (q_out),
		.pop          (q_pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

endmodule

`default_nettype wire

@@ design/mvm_front.sv @@
// ----------------------------------------------------------------------------
// mvm_front
// Accepts command transfers, unpacks the fields and classifies arguments.
// ----------------------------------------------------------------------------
`default_nettype none

module mvm_front #(
	parameter int VOICES       = 16,
	parameter int VOICE_FRAMES = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	input  wire logic [103:0]       s_axis_tdata,
	input  wire logic               q_full,
	output logic                    q_push,
	output mvm_pkg::cmd_item_t      q_item
);

	localparam int SLOT_WORDS = 2 * VOICE_FRAMES;

	logic [12:0] idx;
	logic [12:0] frames;
	logic [3:0]  vce;
	logic        seen_q;

	assign vce    = s_axis_tdata[6:3];
	assign idx    = s_axis_tdata[19:7];
	assign frames = s_axis_tdata[48:36];

	assign s_axis_tready = !q_full && seen_q;
	assign q_push        = s_axis_tvalid && s_axis_tready;

	// hold off the first transfer until reset has been released
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else begin
			seen_q <= 1'b1;
		end
	end

	always_comb begin
		q_item.op           = mvm_pkg::cmd_t'(s_axis_tdata[2:0]);
		q_item.voice        = vce;
		q_item.sample_index = idx;
		q_item.sample_value = s_axis_tdata[35:20];
		q_item.frame_count  = frames;
		q_item.stereo       = s_axis_tdata[49];
		q_item.volume       = s_axis_tdata[65:50];
		q_item.pan          = s_axis_tdata[81:66];
		q_item.lowpass      = s_axis_tdata[97:82];
		q_item.loop_enable  = s_axis_tdata[98];
		q_item.voice_ok     = 32'(vce) < VOICES;
		q_item.index_ok     = 32'(idx) < SLOT_WORDS;
		q_item.frames_ok    = (frames != 13'd0) && (32'(frames) <= VOICE_FRAMES);
	end

endmodule

`default_nettype wire

@@ design/mvm_cmd_q.sv @@
// ----------------------------------------------------------------------------
// mvm_cmd_q
// Short command queue between the front and the voice engine.
// ----------------------------------------------------------------------------
`default_nettype none

module mvm_cmd_q (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire mvm_pkg::cmd_item_t push_item,
	output logic                    full,
	input  wire logic               pop,
	output logic                    item_valid,
	output mvm_pkg::cmd_item_t      item
);

	mvm_pkg::cmd_item_t             store_q [mvm_pkg::QUEUE_DEPTH];
	logic [mvm_pkg::QUEUE_AW-1:0]   wr_q;
	logic [mvm_pkg::QUEUE_AW-1:0]   rd_q;
	logic [mvm_pkg::QUEUE_AW:0]     cnt_q;

	assign full       = cnt_q == (mvm_pkg::QUEUE_AW+1)'(mvm_pkg::QUEUE_DEPTH);
	assign item_valid = cnt_q != '0;
	assign item       = store_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

@@ design/mvm_engine.sv @@
// ----------------------------------------------------------------------------
// mvm_engine
// Voice state, sample store and the per-voice mix sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mvm_engine #(
	parameter int VOICES       = 16,
	parameter int VOICE_FRAMES = 4096,
	parameter int PAN_STEPS    = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	input  wire mvm_pkg::cmd_item_t item,
	output logic                    pop,
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	output logic [47:0]             m_axis_tdata
);

	localparam int SLOT   = 2 * VOICE_FRAMES;
	localparam int VW     = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CW     = $clog2(VOICES + 1);
	localparam int PW     = $clog2(VOICE_FRAMES + 1);
	localparam int IW     = $clog2(SLOT);
	localparam int AW     = $clog2(VOICES * SLOT);
	localparam int KW     = $clog2(PAN_STEPS + 1);
	localparam int ACC_W  = 50 + $clog2(VOICES + 1);
	localparam logic signed [ACC_W-1:0] ONE_Q44 = ACC_W'(1) <<< 44;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHK, ST_RDR, ST_GET, ST_FLT_L, ST_FLT_LW, ST_FLT_RW,
		ST_MUL_L1, ST_MUL_L2, ST_MUL_R2, ST_FIN
	} state_t;

	state_t                  state_q;
	logic [VOICES-1:0]       active_q;
	logic [VW-1:0]           vi_q;
	logic signed [ACC_W-1:0] acc_l_q;
	logic signed [ACC_W-1:0] acc_r_q;
	logic signed [15:0]      left_q;
	logic signed [15:0]      right_q;
	logic [VW-1:0]           id_q;
	logic                    status_q;
	logic                    fin_q;
	logic                    out_valid_q;

	logic [PW-1:0]           pos_q    [VOICES];
	logic [PW-1:0]           len_q    [VOICES];
	logic                    st_q     [VOICES];
	logic                    loop_q   [VOICES];
	logic [15:0]             gain_q   [VOICES];
	logic signed [15:0]      pan_q    [VOICES];
	logic [15:0]             amt_q    [VOICES];
	logic signed [15:0]      fl_q     [VOICES];
	logic signed [15:0]      fr_q     [VOICES];
	logic signed [15:0]      smem_q   [VOICES * SLOT];
	logic signed [15:0]      rdata_q;
	logic [AW-1:0]           raddr_q;
	logic signed [15:0]      sl_q;
	logic signed [15:0]      sr_q;
	logic [16:0]             alpha_q;
	logic [KW-1:0]           k_q;
	logic [15:0]             gl_q;
	logic [15:0]             gr_q;
	logic signed [34:0]      prod_q;
	logic signed [32:0]      p1_q;

	logic [15:0]             sine_tbl [PAN_STEPS + 1];

	// Q30 Taylor series of sin, rounded to a Q1.15 gain in 0..32768
	for (genvar j = 0; j <= PAN_STEPS; j++) begin : g_sine
		localparam longint SX  = (longint'(j) * mvm_pkg::HALF_PI_Q30) / PAN_STEPS;
		localparam longint SX2 = (SX * SX) >>> 30;
		localparam longint T1  = ((SX * SX2) >>> 30) / 6;
		localparam longint T2  = ((T1 * SX2) >>> 30) / 20;
		localparam longint T3  = ((T2 * SX2) >>> 30) / 42;
		localparam longint T4  = ((T3 * SX2) >>> 30) / 72;
		localparam longint T5  = ((T4 * SX2) >>> 30) / 110;
		localparam longint T6  = ((T5 * SX2) >>> 30) / 156;
		localparam longint T7  = ((T6 * SX2) >>> 30) / 210;
		localparam longint SS  = SX - T1 + T2 - T3 + T4 - T5 + T6 - T7;
		localparam longint SR  = (SS + 64'sd16384) >>> 15;
		localparam logic [15:0] SG = (SR < 0) ? 16'd0 : ((SR > 32768) ? 16'd32768 : 16'(SR));
		assign sine_tbl[j] = SG;
	end

	logic                    go;
	logic [VW-1:0]           cv;
	logic                    free_found;
	logic [VW-1:0]           free_idx;
	logic [CW-1:0]           count;
	logic                    chk_wrap;
	logic                    chk_skip;
	logic [PW-1:0]           chk_pos;
	logic [IW-1:0]           chk_off;
	logic [AW-1:0]           rd_addr;
	logic                    rd_en;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic                    last_voice;
	logic [33:0]             amt_mul;
	logic [16:0]             alpha_nx;
	logic [31:0]             k_mul;
	logic [KW-1:0]           k_nx;
	logic signed [19:0]      flt_new;
	logic signed [15:0]      flt_old;
	logic signed [16:0]      flt_in;
	logic signed [49:0]      p2;
	logic signed [15:0]      res_l;
	logic signed [15:0]      res_r;

	function automatic logic signed [15:0] to_s16(logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] a;
		logic [44:0]             mag;
		logic [59:0]             m;
		logic [15:0]             r;
		a = acc;
		if (a > ONE_Q44) begin
			a = ONE_Q44;
		end
		if (a < -ONE_Q44) begin
			a = -ONE_Q44;
		end
		mag = a[ACC_W-1] ? 45'(-a) : 45'(a);
		m   = (60'(mag) << 15) - 60'(mag);
		r   = 16'(m >> 44);
		return a[ACC_W-1] ? -$signed(r) : $signed(r);
	endfunction

	assign go         = (state_q == ST_IDLE) && item_valid && !out_valid_q;
	assign pop        = go;
	assign cv         = VW'(item.voice);
	assign last_voice = vi_q == VW'(VOICES - 1);

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int v = VOICES - 1; v >= 0; v--) begin
			if (!active_q[v]) begin
				free_found = 1'b1;
				free_idx   = VW'(v);
			end
		end
	end

	always_comb begin
		count = '0;
		for (int v = 0; v < VOICES; v++) begin
			count = count + CW'(active_q[v]);
		end
	end

	assign chk_wrap = pos_q[vi_q] >= len_q[vi_q];
	assign chk_skip = !active_q[vi_q] || (chk_wrap && !loop_q[vi_q]);
	assign chk_pos  = chk_wrap ? '0 : pos_q[vi_q];
	assign chk_off  = st_q[vi_q] ? IW'({chk_pos, 1'b0}) : IW'(chk_pos);

	assign amt_mul  = 34'(amt_q[vi_q]) * 34'(mvm_pkg::LP_SCALE) + 34'd32768;
	assign alpha_nx = 17'd65536 - 17'(amt_mul >> 16);
	assign k_mul    = 32'({~pan_q[vi_q][15], pan_q[vi_q][14:0]}) * 32'(PAN_STEPS) + 32'd32768;
	assign k_nx     = (32'(k_mul >> 16) > 32'(PAN_STEPS)) ? KW'(PAN_STEPS) : KW'(k_mul >> 16);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = raddr_q + AW'(st_q[vi_q]);
		if (state_q == ST_CHK && !chk_skip) begin
			rd_en   = 1'b1;
			rd_addr = AW'(vi_q) * AW'(SLOT) + AW'(chk_off);
		end else if (state_q == ST_RDR) begin
			rd_en = 1'b1;
		end
	end

	assign wr_en   = go && item.op == mvm_pkg::CMD_WRITE && item.voice_ok && item.index_ok;
	assign wr_addr = AW'(cv) * AW'(SLOT) + AW'(IW'(item.sample_index));

	always_comb begin
		flt_old = (state_q == ST_FLT_LW) ? fl_q[vi_q] : fr_q[vi_q];
		flt_new = 20'(flt_old) + 20'((36'(prod_q) + 36'sd32768) >>> 16);
		flt_in  = (state_q == ST_FLT_L) ? 17'(sl_q) - 17'(fl_q[vi_q])
		                                : 17'(sr_q) - 17'(fr_q[vi_q]);
	end

	assign p2    = p1_q * $signed({1'b0, (state_q == ST_MUL_L2) ? gl_q : gr_q});
	assign res_l = to_s16(acc_l_q);
	assign res_r = to_s16(acc_r_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			smem_q[wr_addr] <= item.sample_value;
		end
		if (rd_en) begin
			rdata_q <= smem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= '0;
			vi_q        <= '0;
			acc_l_q     <= '0;
			acc_r_q     <= '0;
			left_q      <= '0;
			right_q     <= '0;
			id_q        <= '0;
			status_q    <= 1'b0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (go) begin
						left_q   <= '0;
						right_q  <= '0;
						id_q     <= '0;
						status_q <= 1'b0;
						fin_q    <= 1'b0;
						out_valid_q <= item.op != mvm_pkg::CMD_MIX;
						case (item.op)
							mvm_pkg::CMD_PLAY: begin
								if (item.frames_ok && free_found) begin
									active_q[free_idx] <= 1'b1;
									id_q               <= free_idx;
								end else begin
									status_q <= 1'b1;
								end
							end
							mvm_pkg::CMD_WRITE: begin
								status_q <= !(item.voice_ok && item.index_ok);
							end
							mvm_pkg::CMD_SPATIAL: begin
								status_q <= !item.voice_ok;
							end
							mvm_pkg::CMD_STOP: begin
								if (item.voice_ok) begin
									active_q[cv] <= 1'b0;
								end else begin
									status_q <= 1'b1;
								end
							end
							mvm_pkg::CMD_STOPALL: begin
								active_q <= '0;
							end
							mvm_pkg::CMD_MIX: begin
								vi_q        <= '0;
								acc_l_q     <= '0;
								acc_r_q     <= '0;
								state_q     <= ST_CHK;
							end
							mvm_pkg::CMD_QUERY: begin
								status_q <= !item.voice_ok;
								fin_q    <= item.voice_ok ? !active_q[cv] : 1'b1;
							end
							default: begin
								status_q <= 1'b1;
							end
						endcase
					end
				end
				ST_CHK: begin
					if (chk_skip) begin
						active_q[vi_q] <= 1'b0;
						if (last_voice) begin
							state_q <= ST_FIN;
						end else begin
							vi_q <= vi_q + 1'b1;
						end
					end else begin
						if (chk_pos + 1'b1 == len_q[vi_q] && !loop_q[vi_q]) begin
							active_q[vi_q] <= 1'b0;
						end
						state_q <= ST_RDR;
					end
				end
				ST_RDR: begin
					state_q <= ST_GET;
				end
				ST_GET: begin
					state_q <= (32'(amt_q[vi_q]) > mvm_pkg::LP_THRESHOLD) ? ST_FLT_L : ST_MUL_L1;
				end
				ST_FLT_L: begin
					state_q <= ST_FLT_LW;
				end
				ST_FLT_LW: begin
					state_q <= ST_FLT_RW;
				end
				ST_FLT_RW: begin
					state_q <= ST_MUL_L1;
				end
				ST_MUL_L1: begin
					state_q <= ST_MUL_L2;
				end
				ST_MUL_L2: begin
					acc_l_q <= acc_l_q + ACC_W'(p2);
					state_q <= ST_MUL_R2;
				end
				ST_MUL_R2: begin
					acc_r_q <= acc_r_q + ACC_W'(p2);
					if (last_voice) begin
						state_q <= ST_FIN;
					end else begin
						vi_q    <= vi_q + 1'b1;
						state_q <= ST_CHK;
					end
				end
				ST_FIN: begin
					left_q      <= res_l;
					right_q     <= res_r;
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (go && item.op == mvm_pkg::CMD_PLAY && item.frames_ok && free_found) begin
					len_q[free_idx]  <= PW'(item.frame_count);
					st_q[free_idx]   <= item.stereo;
					pos_q[free_idx]  <= '0;
					gain_q[free_idx] <= item.volume;
					pan_q[free_idx]  <= item.pan;
					amt_q[free_idx]  <= '0;
					fl_q[free_idx]   <= '0;
					fr_q[free_idx]   <= '0;
					loop_q[free_idx] <= item.loop_enable;
				end
				if (go && item.op == mvm_pkg::CMD_SPATIAL && item.voice_ok) begin
					gain_q[cv] <= item.volume;
					pan_q[cv]  <= item.pan;
					amt_q[cv]  <= item.lowpass;
				end
			end
			ST_CHK: begin
				if (!chk_skip) begin
					pos_q[vi_q] <= chk_pos + 1'b1;
				end
				raddr_q <= rd_addr;
				alpha_q <= alpha_nx;
				k_q     <= k_nx;
			end
			ST_RDR: begin
				sl_q <= rdata_q;
			end
			ST_GET: begin
				sr_q <= rdata_q;
				gl_q <= sine_tbl[KW'(PAN_STEPS) - k_q];
				gr_q <= sine_tbl[k_q];
			end
			ST_FLT_L: begin
				prod_q <= $signed({1'b0, alpha_q}) * flt_in;
			end
			ST_FLT_LW: begin
				fl_q[vi_q] <= 16'(flt_new);
				sl_q       <= 16'(flt_new);
				prod_q     <= $signed({1'b0, alpha_q}) * flt_in;
			end
			ST_FLT_RW: begin
				fr_q[vi_q] <= 16'(flt_new);
				sr_q       <= 16'(flt_new);
			end
			ST_MUL_L1: begin
				p1_q <= sl_q * $signed({1'b0, gain_q[vi_q]});
			end
			ST_MUL_L2: begin
				p1_q <= sr_q * $signed({1'b0, gain_q[vi_q]});
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, fin_q, 5'(count), status_q, 4'(id_q), right_q, left_q};

endmodule

`default_nettype wire
